@@ rtl/b64e_pkg.sv @@
// Package for the Base64 encoder: alphabet, symbol and job types, queue depth.
package b64e_pkg;

   localparam int QUEUE_DEPTH = 2;
   localparam int SLOTS       = 4;

   localparam logic [7:0] PAD_CHAR = 8'h3D;

   // Phase codes: position of the next byte within its 3-byte group
   localparam logic [1:0] PH_FIRST  = 2'd0;
   localparam logic [1:0] PH_SECOND = 2'd1;
   localparam logic [1:0] PH_THIRD  = 2'd2;

   localparam logic [7:0] ALPHABET [0:63] = '{
      "z","y","0","x","w","1","v","u","2","t","s","3","r","q","4","p",
      "o","5","n","m","6","l","k","7","j","i","8","h","g","9","f","e",
      "d","c","b","a",",",".","Z","Y","X","W","V","U","T","S","R","Q",
      "P","O","N","M","L","K","J","I","H","G","F","E","D","C","B","A"
   };

   // One output character to be produced: a 6-bit code or a pad
   typedef struct packed {
      logic       pad;
      logic [5:0] code;
   } slot_type;

   // All characters caused by one input word
   typedef struct packed {
      slot_type [SLOTS-1:0] slots;
      logic [1:0]           last_slot;
      logic                 final_item;
   } job_type;

   // Write side of the job queue
   typedef struct packed {
      logic    push;
      job_type job;
   } job_push_type;

   // Read side of the job queue
   typedef struct packed {
      logic    valid;
      job_type job;
   } job_head_type;

   function automatic logic [7:0] slot_char(slot_type s);
      logic [7:0] ch;
      if (s.pad) begin
         ch = PAD_CHAR;
      end else begin
         ch = ALPHABET[s.code];
      end
      return ch;
   endfunction

endpackage

@@ rtl/b64e_if.sv @@
// Valid/ready channel interfaces for the encoder's byte input and character output.
interface b64e_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       final_byte;

   modport source (output valid, output data_byte, output final_byte, input ready);
   modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

interface b64e_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       end_of_text;

   modport source (output valid, output out_char, output end_of_text, input ready);
   modport sink (input valid, input out_char, input end_of_text, output ready);
endinterface

@@ rtl/b64e_front.sv @@
// Front end: accepts bytes, tracks the group phase and builds a job of 6-bit codes.
module b64e_front (
   input  logic                  clock,
   input  logic                  reset,
   b64e_req_if.sink              req_chan,
   input  logic                  queue_full,
   output b64e_pkg::job_push_type job_push
);
   import b64e_pkg::*;

   logic [1:0] phase_ff, phase_in;
   logic [7:0] prev_ff, prev_in;
   logic       accept;
   logic [7:0] c;
   logic [7:0] l;
   logic [1:0] next_phase;
   job_type    job;

   assign accept = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !queue_full;
   assign c = req_chan.data_byte;
   assign l = prev_ff;

   // Build the character codes for this word, plus flush and padding on the last one
   always_comb begin
      job = '0;
      unique case (phase_ff)
         PH_SECOND: begin
            job.slots[0].code = {l[1:0], c[7:4]};
            job.last_slot = 2'd0;
            next_phase = PH_THIRD;
         end
         PH_THIRD: begin
            job.slots[0].code = {l[3:0], c[7:6]};
            job.slots[1].code = c[5:0];
            job.last_slot = 2'd1;
            next_phase = PH_FIRST;
         end
         default: begin
            job.slots[0].code = c[7:2];
            job.last_slot = 2'd0;
            next_phase = PH_SECOND;
         end
      endcase
      job.final_item = req_chan.final_byte;
      if (req_chan.final_byte) begin
         // Flush the leftover bits; group with one byte gets two pads, two bytes one pad
         if (next_phase == PH_SECOND) begin
            job.slots[1].code = {c[1:0], 4'b0000};
            job.slots[2].pad = 1'b1;
            job.slots[3].pad = 1'b1;
            job.last_slot = 2'd3;
         end else if (next_phase == PH_THIRD) begin
            job.slots[1].code = {c[3:0], 2'b00};
            job.slots[2].pad = 1'b1;
            job.last_slot = 2'd2;
         end
      end
   end

   assign job_push.push = accept;
   assign job_push.job  = job;

   // Phase and previous byte return to zero at end of message
   always_comb begin
      phase_in = phase_ff;
      prev_in  = prev_ff;
      if (accept) begin
         if (req_chan.final_byte) begin
            phase_in = PH_FIRST;
            prev_in  = 8'h00;
         end else begin
            phase_in = next_phase;
            prev_in  = c;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_FIRST;
         prev_ff  <= 8'h00;
      end else begin
         phase_ff <= phase_in;
         prev_ff  <= prev_in;
      end
   end

`ifndef NO_ASSERTIONS
   // The unused phase code is never reached
   a_phase_legal: assert property (@(posedge clock) disable iff (reset)
      phase_ff != 2'd3)
      else $error("front: phase reached unused code");

   // A final word always leaves the phase at the group start
   a_final_resets_phase: assert property (@(posedge clock) disable iff (reset)
      accept && req_chan.final_byte |=> phase_ff == PH_FIRST && prev_ff == 8'h00)
      else $error("front: phase not cleared after final word");
`endif

endmodule

@@ rtl/b64e_queue.sv @@
// Short job queue between front and back; registers with read and write pointers.
module b64e_queue #(
   parameter int DEPTH = b64e_pkg::QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  b64e_pkg::job_push_type job_push,
   input  logic                   pop,
   output logic                   full,
   output b64e_pkg::job_head_type head
);
   import b64e_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   job_type          mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = count_ff == FULL_CNT;
   assign do_push  = job_push.push && !full;
   assign do_pop   = pop && head.valid;
   assign head.valid = count_ff != '0;
   assign head.job   = mem_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage: written at the write pointer only
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= job_push.job;
      end
   end

`ifndef NO_ASSERTIONS
   // Fill count never exceeds the depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("queue: fill count above depth");

   // The front never pushes into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      job_push.push |-> !full)
      else $error("queue: push while full");
`endif

endmodule

@@ rtl/b64e_back.sv @@
// Back end: walks the queued job into the output register, one character per cycle unless rsp_chan stalls.
module b64e_back (
   input  logic                   clock,
   input  logic                   reset,
   input  b64e_pkg::job_head_type head,
   output logic                   pop,
   b64e_rsp_if.source             rsp_chan
);
   import b64e_pkg::*;

   logic [1:0] slot_ff, slot_in;
   logic       valid_ff, valid_in;
   logic [7:0] char_ff, char_in;
   logic       eot_ff, eot_in;
   logic       emit;
   logic       last_slot;

   assign emit      = head.valid && (!valid_ff || rsp_chan.ready);
   assign last_slot = slot_ff == head.job.last_slot;
   assign pop       = emit && last_slot;

   // Select the current slot and look up its character
   always_comb begin
      slot_in  = slot_ff;
      valid_in = valid_ff && !rsp_chan.ready;
      char_in  = char_ff;
      eot_in   = eot_ff;
      if (emit) begin
         valid_in = 1'b1;
         char_in  = slot_char(head.job.slots[slot_ff]);
         eot_in   = head.job.final_item && last_slot;
         slot_in  = last_slot ? 2'd0 : slot_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff  <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         slot_ff  <= slot_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      eot_ff  <= eot_in;
   end

   assign rsp_chan.valid       = valid_ff;
   assign rsp_chan.out_char    = char_ff;
   assign rsp_chan.end_of_text = eot_ff;

`ifndef NO_ASSERTIONS
   // Slot index stays within the head job's character count
   a_slot_in_range: assert property (@(posedge clock) disable iff (reset)
      head.valid |-> slot_ff <= head.job.last_slot)
      else $error("back: slot index beyond job");

   // The slot index returns to zero whenever a job is retired
   a_slot_rewinds: assert property (@(posedge clock) disable iff (reset)
      pop |=> slot_ff == 2'd0)
      else $error("back: slot index not rewound after job");
`endif

endmodule

@@ rtl/base64_encoder_custom_alphabet.sv @@
// Top level of the streaming Base64 encoder with a fixed custom alphabet.
// Takes one message byte per word on req_chan and emits encoded characters, one per word,
// on rsp_chan; the word marked final_byte flushes the group, adds '=' padding and marks
// its last character with end_of_text. A byte is taken in the cycle it is offered as long
// as the job queue (QUEUE_DEPTH entries) has room; its characters then pass through the
// queue and the output register. The output side produces one character per cycle unless
// rsp_chan stalls, so throughput is set by the character count: about 4/3 characters per
// byte in a long message, 1 or 2 for an ordinary byte and up to 4 for a final byte. The
// output register lets a new byte enter while a finished character still waits to be taken.
module base64_encoder_custom_alphabet #(
   parameter int QUEUE_DEPTH = b64e_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   b64e_req_if.sink    req_chan,
   b64e_rsp_if.source  rsp_chan
);
   import b64e_pkg::*;

   job_push_type job_push;
   job_head_type head;
   logic         queue_full;
   logic         pop;

   b64e_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .job_push   (job_push)
   );

   b64e_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .job_push (job_push),
      .pop      (pop),
      .full     (queue_full),
      .head     (head)
   );

   b64e_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

@@ dv/tb_base64_encoder_custom_alphabet.sv @@
// Testbench for the custom-alphabet Base64 encoder: directed and random messages, predicted characters.
`timescale 1ns / 1ps

module tb_base64_encoder_custom_alphabet;
   import b64e_pkg::*;

   // Encoding table, first character is code 0
   localparam logic [0:63][7:0] CHARSET =
      "zy0xw1vu2ts3rq4po5nm6lk7ji8hg9fedcba,.ZYXWVUTSRQPONMLKJIHGFEDCBA";
   localparam logic [7:0] PAD_SYM = "=";

   localparam int RANDOM_BYTES = 400;
   localparam int CALM_WORDS   = 60;    // no idling once this few bytes are left
   localparam int DRAIN_CYCLES = 10;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } msg_byte_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       eot;
   } enc_char_type;

   logic clock;
   logic reset;

   b64e_req_if req_chan();
   b64e_rsp_if rsp_chan();

   base64_encoder_custom_alphabet i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   msg_byte_type  pending_bytes [$];
   enc_char_type  expected_chars [$];
   int            mismatch_count = 0;

   // Encoder state mirror
   logic [1:0] enc_phase = PH_FIRST;
   logic [7:0] enc_prev  = 8'h00;

   int gap_left   = 0;
   int stall_left = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic report(input string what);
      $display("%0t ns: mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   function automatic enc_char_type code_char(input logic [5:0] code);
      enc_char_type c;
      c.ch  = CHARSET[code];
      c.eot = 1'b0;
      return c;
   endfunction

   function automatic enc_char_type pad_char();
      enc_char_type c;
      c.ch  = PAD_SYM;
      c.eot = 1'b0;
      return c;
   endfunction

   // Characters caused by one accepted byte, appended to expected_chars
   task automatic encode_byte(input logic [7:0] c, input logic last);
      logic [1:0]    next_phase;
      enc_char_type  tail;
      case (enc_phase)
         PH_SECOND: begin
            expected_chars.push_back(code_char({enc_prev[1:0], c[7:4]}));
            next_phase = PH_THIRD;
         end
         PH_THIRD: begin
            expected_chars.push_back(code_char({enc_prev[3:0], c[7:6]}));
            expected_chars.push_back(code_char(c[5:0]));
            next_phase = PH_FIRST;
         end
         default: begin
            // first byte of a group; the unused code behaves the same
            expected_chars.push_back(code_char(c[7:2]));
            next_phase = PH_SECOND;
         end
      endcase
      if (last) begin
         // flush leftover bits and pad out the group
         if (next_phase == PH_SECOND) begin
            expected_chars.push_back(code_char({c[1:0], 4'b0000}));
            expected_chars.push_back(pad_char());
            expected_chars.push_back(pad_char());
         end else if (next_phase == PH_THIRD) begin
            expected_chars.push_back(code_char({c[3:0], 2'b00}));
            expected_chars.push_back(pad_char());
         end
         tail = expected_chars.pop_back();
         tail.eot = 1'b1;
         expected_chars.push_back(tail);
         enc_phase = PH_FIRST;
         enc_prev  = 8'h00;
      end else begin
         enc_phase = next_phase;
         enc_prev  = c;
      end
   endtask

   task automatic add_message(input int len, input logic [7:0] fixed [$]);
      msg_byte_type b;
      for (int i = 0; i < len; i++) begin
         b.data = (fixed.size() != 0) ? fixed[i] : 8'($urandom);
         b.last = (i == len - 1);
         pending_bytes.push_back(b);
      end
   endtask

   // Input driver: offers queued bytes, idles in bursts
   always @(posedge clock) begin
      logic held;
      held = req_chan.valid && !req_chan.ready;
      if (reset) begin
         req_chan.valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            encode_byte(pending_bytes[0].data, pending_bytes[0].last);
            void'(pending_bytes.pop_front());
         end
         if (held) begin
            req_chan.valid <= 1'b1;
         end else if (gap_left != 0) begin
            gap_left--;
            req_chan.valid <= 1'b0;
         end else if (pending_bytes.size() > CALM_WORDS && $urandom_range(0, 7) == 0) begin
            gap_left = $urandom_range(0, 7);
            req_chan.valid <= 1'b0;
         end else if (pending_bytes.size() != 0) begin
            req_chan.valid      <= 1'b1;
            req_chan.data_byte  <= pending_bytes[0].data;
            req_chan.final_byte <= pending_bytes[0].last;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // Output monitor: checks each character word, stalls in bursts
   always @(posedge clock) begin
      enc_char_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_chars.size() == 0) begin
               report($sformatf("unexpected character 0x%02h", rsp_chan.out_char));
            end else begin
               want = expected_chars.pop_front();
               if (rsp_chan.out_char !== want.ch)
                  report($sformatf("out_char 0x%02h, want 0x%02h",
                                   rsp_chan.out_char, want.ch));
               if (rsp_chan.end_of_text !== want.eot)
                  report($sformatf("end_of_text %b, want %b",
                                   rsp_chan.end_of_text, want.eot));
            end
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else if (pending_bytes.size() > CALM_WORDS && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 7);
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Stimulus and end of run
   initial begin
      logic [7:0] pattern [$];
      logic [7:0] picked  [$];
      logic [7:0] none    [$];
      int         lengths [$];
      int         k;
      int         random_total;
      int         len;

      req_chan.valid      = 1'b0;
      req_chan.data_byte  = 8'h00;
      req_chan.final_byte = 1'b0;
      rsp_chan.ready      = 1'b0;
      reset               = 1'b1;

      // Directed: short messages covering every group position and flush case
      pattern = '{8'h00, 8'hFF, 8'hAA, 8'h55, 8'h0F, 8'hF0, 8'h01, 8'h80};
      lengths = '{1, 1, 2, 3, 4, 5, 6};
      k = 0;
      foreach (lengths[m]) begin
         picked = {};
         for (int i = 0; i < lengths[m]; i++) begin
            picked.push_back(pattern[k % pattern.size()]);
            k++;
         end
         add_message(lengths[m], picked);
      end

      // Random messages, mostly short, some long
      random_total = 0;
      while (random_total < RANDOM_BYTES) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
         add_message(len, none);
         random_total += len;
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      wait (pending_bytes.size() == 0);
      wait (expected_chars.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #400000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

@@ base64_encoder_custom_alphabet.f @@
rtl/b64e_pkg.sv
rtl/b64e_if.sv
rtl/b64e_front.sv
rtl/b64e_queue.sv
rtl/b64e_back.sv
rtl/base64_encoder_custom_alphabet.sv
dv/tb_base64_encoder_custom_alphabet.sv
